/* rtl/pps_pkg.sv */
// Shared constants, codes and the arctangent table of the pure pursuit steering unit.
// Has no dependencies. Imported by pure_pursuit_steering_unit.
package pps_pkg;

   localparam int PATH_DEPTH    = 1024;
   localparam int ADDR_W        = $clog2(PATH_DEPTH);
   localparam int CNT_W         = ADDR_W + 1;
   localparam int INDEX_BACKOFF = 5;

   localparam int CW = 46;   // CORDIC datapath width
   localparam int ZW = 20;   // CORDIC angle width, Q16

   localparam logic signed [CW-1:0] NORM_LIM  = CW'(64'sd1099511627776);
   localparam logic signed [CW-1:0] CORDIC_K  = CW'(64'sd652032874);
   localparam logic signed [CW-1:0] ONE_Q28   = CW'(64'sd268435456);
   localparam logic signed [ZW-1:0] PI_Q16    = ZW'(205888);
   localparam logic signed [ZW-1:0] HPI_Q16   = ZW'(102944);
   localparam logic signed [16:0]   PI_Q13    = 17'sd25736;
   localparam logic signed [16:0]   TWO_PI_Q13 = 17'sd51472;
   localparam logic signed [16:0]   HALF_RAD_Q13 = 17'sd4096;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_CONTROL = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_RUNNING   = 2'd0,
      ST_SUCCEEDED = 2'd1,
      ST_FAILED    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_LOOKAHEAD = 2'd0,
      CSR_MAX_SPEED = 2'd1,
      CSR_MAX_TURN  = 2'd2,
      CSR_GOAL_TOL  = 2'd3
   } csr_index_type;

   function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         4'd0:    v = ZW'(51472);
         4'd1:    v = ZW'(30386);
         4'd2:    v = ZW'(16055);
         4'd3:    v = ZW'(8150);
         4'd4:    v = ZW'(4091);
         4'd5:    v = ZW'(2047);
         4'd6:    v = ZW'(1024);
         4'd7:    v = ZW'(512);
         4'd8:    v = ZW'(256);
         4'd9:    v = ZW'(128);
         4'd10:   v = ZW'(64);
         4'd11:   v = ZW'(32);
         4'd12:   v = ZW'(16);
         4'd13:   v = ZW'(8);
         4'd14:   v = ZW'(4);
         default: v = ZW'(2);
      endcase
      return v;
   endfunction

endpackage

/* rtl/pure_pursuit_steering_unit.sv */
// Pure pursuit steering unit: path memory, lookahead search and steering sequencer.
// Depends on pps_pkg for constants, codes and the arctangent table.
// Append and clear items are done in the idle state; a control item on an empty path
// goes straight to the output step. Otherwise a control item runs the goal test, then the
// search point by point, then two CORDIC arctangents with up to 40 normalising doublings
// each, the sine, a 32-step square root and a 62-step divide. One item at a time; a waiting
// result holds the input. Synchronous active-high reset empties the path and loads defaults.
module pure_pursuit_steering_unit
   import pps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // pos_x, pos_y, quat_w, quat_x, quat_y, quat_z
   input  logic [1:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // forward speed, turn rate, zero pad
   output logic [1:0]   rsp_tuser,   // status
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_GOAL, S_WAIT, S_LOAD, S_SQX, S_SQY, S_CMP, S_TRD,
      S_Q0, S_Q1, S_Q2, S_Q3, S_YSET, S_ANORM, S_AROT, S_CITER, S_AEND,
      S_SSET, S_SEND, S_LSH, S_LSQX, S_LSQY, S_SQRT, S_MUL, S_DSET, S_DIV,
      S_DEND, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_GOAL, PH_SEARCH, PH_TARGET
   } phase_type;

   state_type  state_ff;
   phase_type  phase_ff;

   logic [30:0] lookahead_distance_ff, max_linear_speed_ff, max_turn_rate_ff, goal_tolerance_ff;

   logic [63:0] mem [PATH_DEPTH];
   logic [63:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic        mem_we;

   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] ss_ff, idx_ff, found_ff;

   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;

   logic signed [32:0] tx_ff, ty_ff;
   logic [32:0] ax_ff, ay_ff;
   logic        far_ff;
   logic [63:0] acc_ff;
   logic [61:0] rsq_ff;
   logic signed [31:0] sy_ff, sc_ff;

   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic [3:0]  iter_ff;
   logic        vec_ff, atan_sel_ff;
   logic signed [15:0] yaw_ff;
   logic signed [16:0] err_ff;
   logic signed [31:0] sin_ff;
   logic [30:0] speed_ff;
   logic [1:0]  sh_ff;

   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [34:0] l_ff;
   logic signed [63:0] num_ff;
   logic [61:0] dn_ff, q_ff;
   logic [47:0] dd_ff, rem_ff;
   logic [5:0]  dcnt_ff;

   logic [1:0]  st_status_ff;
   logic [30:0] st_lin_ff;
   logic signed [31:0] st_ang_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [30:0] rsp_lin_ff;
   logic signed [31:0] rsp_ang_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   logic signed [CW-1:0] sh_x, sh_y, c_nx, c_ny;
   logic signed [ZW-1:0] c_nz;

   logic signed [32:0] ld_dx, ld_dy;
   logic [32:0] ld_ax, ld_ay;
   logic [CNT_W-1:0] last_c, next_idx;
   logic [62:0] sum_sq;
   logic signed [ZW-1:0] a_r;
   logic signed [15:0] a_q13;
   logic signed [16:0] e_raw, e_wrap;
   logic signed [ZW-1:0] s_z0, s_z;
   logic [63:0] sq_try;
   logic [48:0] rem_sh;
   logic [61:0] q_clamp;
   logic [61:0] num_mag;
   logic req_accept;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_ang_ff, rsp_lin_ff};

   assign mem_we = req_accept && (op_type'(req_tuser) == OP_APPEND)
                   && (count_ff < CNT_W'(PATH_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= {req_tdata[63:32], req_tdata[31:0]};
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_GOAL: begin
            mul_a = $signed({2'b00, goal_tolerance_ff});
            mul_b = $signed({2'b00, goal_tolerance_ff});
         end
         S_CMP: begin
            mul_a = $signed({2'b00, lookahead_distance_ff});
            mul_b = $signed({2'b00, lookahead_distance_ff});
         end
         S_SQX, S_LSQX: begin
            mul_a = $signed({1'b0, ax_ff[31:0]});
            mul_b = $signed({1'b0, ax_ff[31:0]});
         end
         S_SQY, S_LSQY: begin
            mul_a = $signed({1'b0, ay_ff[31:0]});
            mul_b = $signed({1'b0, ay_ff[31:0]});
         end
         S_Q0: begin
            mul_a = 33'(qw_ff);
            mul_b = 33'(qz_ff);
         end
         S_Q1: begin
            mul_a = 33'(qx_ff);
            mul_b = 33'(qy_ff);
         end
         S_Q2: begin
            mul_a = 33'(qy_ff);
            mul_b = 33'(qy_ff);
         end
         S_Q3: begin
            mul_a = 33'(qz_ff);
            mul_b = 33'(qz_ff);
         end
         S_MUL: begin
            mul_a = $signed({2'b00, speed_ff});
            mul_b = 33'(sin_ff);
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      sh_x = cx_ff >>> iter_ff;
      sh_y = cy_ff >>> iter_ff;
      if (vec_ff ? (cy_ff >= 0) : (cz_ff < 0)) begin
         c_nx = cx_ff + sh_y;
         c_ny = cy_ff - sh_x;
         c_nz = cz_ff + atan_q16(iter_ff);
      end else begin
         c_nx = cx_ff - sh_y;
         c_ny = cy_ff + sh_x;
         c_nz = cz_ff - atan_q16(iter_ff);
      end
   end

   always_comb begin
      ld_dx = $signed({rd_data_ff[31], rd_data_ff[31:0]}) - 33'(px_ff);
      ld_dy = $signed({rd_data_ff[63], rd_data_ff[63:32]}) - 33'(py_ff);
      ld_ax = ld_dx[32] ? 33'(-ld_dx) : 33'(ld_dx);
      ld_ay = ld_dy[32] ? 33'(-ld_dy) : 33'(ld_dy);
      last_c   = count_ff - CNT_W'(1);
      next_idx = CNT_W'(idx_ff) + CNT_W'(1);
      sum_sq   = acc_ff[62:0];
      a_r = (cz_ff + ZW'(4)) >>> 3;
      if (a_r > ZW'(PI_Q13)) begin
         a_q13 = 16'(PI_Q13);
      end else if (a_r < -ZW'(PI_Q13)) begin
         a_q13 = -16'(PI_Q13);
      end else begin
         a_q13 = 16'(a_r);
      end
      e_raw = 17'(a_q13) - 17'(yaw_ff);
      if (e_raw > PI_Q13) begin
         e_wrap = e_raw - TWO_PI_Q13;
      end else if (e_raw < -PI_Q13) begin
         e_wrap = e_raw + TWO_PI_Q13;
      end else begin
         e_wrap = e_raw;
      end
      s_z0 = ZW'(err_ff) <<< 3;
      if (s_z0 > HPI_Q16) begin
         s_z = PI_Q16 - s_z0;
      end else if (s_z0 < -HPI_Q16) begin
         s_z = -PI_Q16 - s_z0;
      end else begin
         s_z = s_z0;
      end
      sq_try  = sq_res_ff + sq_bit_ff;
      rem_sh  = {rem_ff, dn_ff[61]};
      q_clamp = (q_ff > 62'(max_turn_rate_ff)) ? 62'(max_turn_rate_ff) : q_ff;
      num_mag = num_ff[63] ? 62'(-num_ff) : 62'(num_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= S_IDLE;
         phase_ff              <= PH_GOAL;
         count_ff              <= '0;
         ss_ff                 <= '0;
         rsp_valid_ff          <= 1'b0;
         lookahead_distance_ff <= 31'd32768;
         max_linear_speed_ff   <= 31'd32768;
         max_turn_rate_ff      <= 31'd65536;
         goal_tolerance_ff     <= 31'd6554;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LOOKAHEAD: lookahead_distance_ff <= csr_data;
               CSR_MAX_SPEED: max_linear_speed_ff   <= csr_data;
               CSR_MAX_TURN:  max_turn_rate_ff      <= csr_data;
               CSR_GOAL_TOL:  goal_tolerance_ff     <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  px_ff <= $signed(req_tdata[31:0]);
                  py_ff <= $signed(req_tdata[63:32]);
                  qw_ff <= $signed(req_tdata[79:64]);
                  qx_ff <= $signed(req_tdata[95:80]);
                  qy_ff <= $signed(req_tdata[111:96]);
                  qz_ff <= $signed(req_tdata[127:112]);
                  case (op_type'(req_tuser))
                     OP_APPEND: begin
                        if (mem_we) begin
                           count_ff <= count_ff + CNT_W'(1);
                           ss_ff    <= '0;
                        end
                     end
                     OP_CLEAR: begin
                        count_ff <= '0;
                        ss_ff    <= '0;
                     end
                     OP_CONTROL: begin
                        if (count_ff == '0) begin
                           st_status_ff <= ST_FAILED;
                           st_lin_ff    <= '0;
                           st_ang_ff    <= '0;
                           state_ff     <= S_OUT;
                        end else begin
                           rd_addr_ff <= last_c[ADDR_W-1:0];
                           phase_ff   <= PH_GOAL;
                           state_ff   <= S_GOAL;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_GOAL: begin
               rsq_ff   <= 62'(mul_p);
               state_ff <= S_LOAD;
            end
            S_WAIT: state_ff <= S_LOAD;
            S_LOAD: begin
               tx_ff  <= ld_dx;
               ty_ff  <= ld_dy;
               ax_ff  <= ld_ax;
               ay_ff  <= ld_ay;
               far_ff <= ld_ax[32] | ld_ax[31] | ld_ay[32] | ld_ay[31];
               state_ff <= (phase_ff == PH_TARGET) ? S_Q0 : S_SQX;
            end
            S_SQX: begin
               acc_ff   <= 64'(mul_p);
               state_ff <= S_SQY;
            end
            S_SQY: begin
               acc_ff   <= acc_ff + 64'(mul_p);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (phase_ff == PH_GOAL) begin
                  if (!far_ff && (sum_sq < 63'(rsq_ff))) begin
                     st_status_ff <= ST_SUCCEEDED;
                     st_lin_ff    <= '0;
                     st_ang_ff    <= '0;
                     state_ff     <= S_OUT;
                  end else begin
                     rsq_ff   <= 62'(mul_p);
                     phase_ff <= PH_SEARCH;
                     if (CNT_W'(ss_ff) < count_ff) begin
                        idx_ff     <= ss_ff;
                        rd_addr_ff <= ss_ff;
                        state_ff   <= S_WAIT;
                     end else begin
                        found_ff <= last_c[ADDR_W-1:0];
                        state_ff <= S_TRD;
                     end
                  end
               end else begin
                  if (far_ff || (sum_sq >= 63'(rsq_ff))) begin
                     found_ff <= idx_ff;
                     state_ff <= S_TRD;
                  end else if (next_idx < count_ff) begin
                     idx_ff     <= next_idx[ADDR_W-1:0];
                     rd_addr_ff <= next_idx[ADDR_W-1:0];
                     state_ff   <= S_WAIT;
                  end else begin
                     found_ff <= last_c[ADDR_W-1:0];
                     state_ff <= S_TRD;
                  end
               end
            end
            S_TRD: begin
               if (CNT_W'(found_ff) > CNT_W'(ss_ff) + CNT_W'(INDEX_BACKOFF)) begin
                  ss_ff <= ADDR_W'(CNT_W'(found_ff) - CNT_W'(INDEX_BACKOFF));
               end
               rd_addr_ff <= found_ff;
               phase_ff   <= PH_TARGET;
               state_ff   <= S_WAIT;
            end
            S_Q0: begin
               sy_ff    <= 32'(mul_p);
               state_ff <= S_Q1;
            end
            S_Q1: begin
               sy_ff    <= sy_ff + 32'(mul_p);
               state_ff <= S_Q2;
            end
            S_Q2: begin
               sc_ff    <= 32'(mul_p);
               state_ff <= S_Q3;
            end
            S_Q3: begin
               sc_ff    <= sc_ff + 32'(mul_p);
               state_ff <= S_YSET;
            end
            S_YSET: begin
               cx_ff       <= ONE_Q28 - (CW'(sc_ff) <<< 1);
               cy_ff       <= CW'(sy_ff) <<< 1;
               cz_ff       <= '0;
               atan_sel_ff <= 1'b0;
               state_ff    <= S_ANORM;
            end
            S_ANORM: begin
               if (cx_ff == '0 && cy_ff == '0) begin
                  state_ff <= S_AEND;
               end else if (cx_ff > -NORM_LIM && cx_ff < NORM_LIM
                            && cy_ff > -NORM_LIM && cy_ff < NORM_LIM) begin
                  cx_ff <= cx_ff <<< 1;
                  cy_ff <= cy_ff <<< 1;
               end else begin
                  state_ff <= S_AROT;
               end
            end
            S_AROT: begin
               if (cx_ff < 0) begin
                  if (cy_ff >= 0) begin
                     cx_ff <= cy_ff;
                     cy_ff <= -cx_ff;
                     cz_ff <= HPI_Q16;
                  end else begin
                     cx_ff <= -cy_ff;
                     cy_ff <= cx_ff;
                     cz_ff <= -HPI_Q16;
                  end
               end
               iter_ff  <= '0;
               vec_ff   <= 1'b1;
               state_ff <= S_CITER;
            end
            S_CITER: begin
               cx_ff   <= c_nx;
               cy_ff   <= c_ny;
               cz_ff   <= c_nz;
               iter_ff <= iter_ff + 4'd1;
               if (iter_ff == 4'd15) begin
                  state_ff <= vec_ff ? S_AEND : S_SEND;
               end
            end
            S_AEND: begin
               if (!atan_sel_ff) begin
                  yaw_ff      <= a_q13;
                  cx_ff       <= CW'(tx_ff);
                  cy_ff       <= CW'(ty_ff);
                  cz_ff       <= '0;
                  atan_sel_ff <= 1'b1;
                  state_ff    <= S_ANORM;
               end else begin
                  err_ff   <= e_wrap;
                  state_ff <= S_SSET;
               end
            end
            S_SSET: begin
               cx_ff    <= CORDIC_K;
               cy_ff    <= '0;
               cz_ff    <= s_z;
               iter_ff  <= '0;
               vec_ff   <= 1'b0;
               state_ff <= S_CITER;
            end
            S_SEND: begin
               sin_ff <= 32'(cy_ff);
               if (err_ff > HALF_RAD_Q13 || err_ff < -HALF_RAD_Q13) begin
                  speed_ff <= max_linear_speed_ff >> 1;
               end else begin
                  speed_ff <= max_linear_speed_ff;
               end
               sh_ff    <= '0;
               state_ff <= S_LSH;
            end
            S_LSH: begin
               if (ax_ff[32] | ax_ff[31] | ay_ff[32] | ay_ff[31]) begin
                  ax_ff <= ax_ff >> 1;
                  ay_ff <= ay_ff >> 1;
                  sh_ff <= sh_ff + 2'd1;
               end else begin
                  state_ff <= S_LSQX;
               end
            end
            S_LSQX: begin
               acc_ff   <= 64'(mul_p);
               state_ff <= S_LSQY;
            end
            S_LSQY: begin
               sq_v_ff   <= acc_ff + 64'(mul_p);
               sq_res_ff <= '0;
               sq_bit_ff <= 64'h4000_0000_0000_0000;
               state_ff  <= S_SQRT;
            end
            S_SQRT: begin
               if (sq_v_ff >= sq_try) begin
                  sq_v_ff   <= sq_v_ff - sq_try;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff == 64'd1) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               l_ff     <= 35'(sq_res_ff) << sh_ff;
               num_ff   <= 64'(mul_p);
               state_ff <= S_DSET;
            end
            S_DSET: begin
               st_status_ff <= ST_RUNNING;
               st_lin_ff    <= speed_ff;
               if (l_ff == '0) begin
                  if (num_ff > 0) begin
                     st_ang_ff <= $signed({1'b0, max_turn_rate_ff});
                  end else if (num_ff < 0) begin
                     st_ang_ff <= -$signed({1'b0, max_turn_rate_ff});
                  end else begin
                     st_ang_ff <= '0;
                  end
                  state_ff <= S_OUT;
               end else begin
                  dn_ff    <= num_mag;
                  dd_ff    <= {l_ff[34:0], 13'd0};
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (rem_sh >= 49'(dd_ff)) begin
                  rem_ff <= 48'(rem_sh - 49'(dd_ff));
                  q_ff   <= {q_ff[60:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[47:0];
                  q_ff   <= {q_ff[60:0], 1'b0};
               end
               dn_ff   <= dn_ff << 1;
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd61) begin
                  state_ff <= S_DEND;
               end
            end
            S_DEND: begin
               st_ang_ff <= num_ff[63] ? -$signed(32'(q_clamp)) : $signed(32'(q_clamp));
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_status_ff;
                  rsp_lin_ff    <= st_lin_ff;
                  rsp_ang_ff    <= st_ang_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PATH_DEPTH))
      else $error("path count beyond depth");

   a_search_in_path: assert property (@(posedge clock) disable iff (reset)
      (ss_ff == '0) || (CNT_W'(ss_ff) < count_ff))
      else $error("search start beyond stored path");

endmodule
